// ----- hw/rtl/bkdk_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkdk_pkg
// Shared types and constants of the bottom-k distinct keeper.
// ----------------------------------------------------------------------------
package bkdk_pkg;

    localparam int unsigned DEFAULT_MAX_KEEP = 64;
    localparam int unsigned VALUE_W          = 32;
    localparam int unsigned KEEP_W           = 7;
    localparam int unsigned KEPT_W           = 7;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [KEEP_W-1:0]  t_keep;

    typedef struct packed {
        logic   mode;
        t_value value;
    } t_in_word;

    typedef struct packed {
        logic [KEPT_W-1:0] kept;
        t_value            largest;
        logic              duplicate;
        logic              dropped_valid;
        t_value            dropped_value;
    } t_out_word;

    // Word travelling down the cell row.
    typedef struct packed {
        logic   live;
        logic   clr;
        logic   fin;
        logic   dup;
        logic   drop;
        t_value value;
        t_value last;
    } t_tok;

endpackage : bkdk_pkg
`default_nettype wire

// ----- hw/rtl/bottom_k_distinct_keeper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bottom_k_distinct_keeper_unit
// Bottom-k sketch: holds the k smallest distinct 32-bit values in a sorted
// row of cells and reports count, largest kept value, a duplicate flag and any dropped value.
// ----------------------------------------------------------------------------
//  port group    dir   handshake                     payload
//  input word    in    i_in_valid / o_in_stall       i_in_word  (t_in_word)
//  result word   out   o_out_valid / i_out_stall     o_out_word (t_out_word)
//  config        in    i_cfg_we                      i_cfg_wdata (keep count)
//
//  One word at a time: it walks the full row of MAX_KEEP cells, one per
//  cycle while the result side does not stall, so a result is registered
//  after every cell, and the next word can be taken once the result shows.
//  Reset empties the store and sets keep count to 0.
//  A stalled result freezes the row once the next word reaches its end.
// ----------------------------------------------------------------------------
module bottom_k_distinct_keeper_unit #(
    parameter int unsigned MAX_KEEP = bkdk_pkg::DEFAULT_MAX_KEEP
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  wire  bkdk_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output bkdk_pkg::t_out_word       o_out_word,
    input  wire                       i_cfg_we,
    input  wire  bkdk_pkg::t_keep     i_cfg_wdata
);
    import bkdk_pkg::*;

    localparam int unsigned CW = $clog2(MAX_KEEP + 1);

    t_keep          r_keep;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           r_busy;
    t_tok           r_in_tok;
    logic           r_out_valid;
    t_out_word      r_out_word;
    t_out_word      n_out_word;
    t_tok           w_tok [MAX_KEEP+1];
    t_tok           w_exit;
    logic           w_adv;
    logic           w_accept;
    logic           w_drop;

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;
    assign w_exit     = w_tok[MAX_KEEP];
    assign w_adv      = !(w_exit.live && r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= '0;
        end else if (i_cfg_we) begin
            r_keep <= i_cfg_wdata;
        end
    end

    // Launch word into the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok.live <= 1'b0;
        end else if (w_accept) begin
            r_in_tok.live  <= 1'b1;
            r_in_tok.clr   <= (i_in_word.mode == MODE_CLEAR);
            r_in_tok.fin   <= 1'b0;
            r_in_tok.dup   <= 1'b0;
            r_in_tok.drop  <= 1'b0;
            r_in_tok.value <= i_in_word.value;
            r_in_tok.last  <= '0;
        end else if (w_adv) begin
            r_in_tok.live <= 1'b0;
        end
    end

    assign w_tok[0] = r_in_tok;

    for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
        bkdk_cell #(
            .MAX_KEEP (MAX_KEEP),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_keep  (r_keep),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // A word leaving the row unfinished found no free slot: drop it
    assign w_drop = !w_exit.clr && !w_exit.dup && (w_exit.drop || !w_exit.fin);

    always_comb begin
        n_count    = r_count;
        n_out_word = '0;
        if (w_exit.clr) begin
            n_count = '0;
        end else begin
            if (!w_exit.dup && !w_drop) begin
                n_count = r_count + CW'(1);
            end
            n_out_word.largest       = w_exit.last;
            n_out_word.duplicate     = w_exit.dup;
            n_out_word.dropped_valid = w_drop;
            n_out_word.dropped_value = w_drop ? w_exit.value : '0;
        end
        n_out_word.kept = KEPT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end
            if (w_exit.live && w_adv) begin
                r_count     <= n_count;
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit.live && w_adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef ASSERT_OFF
    a_exit_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.live |-> r_busy)
        else $error("word leaves row while block is idle");

    a_count_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(MAX_KEEP))
        else $error("held count above row length");

    a_dup_nodrop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_word.duplicate && r_out_word.dropped_valid))
        else $error("duplicate word also reports a drop");

    a_launch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_in_tok.live && r_busy))
        else $error("accepted word not launched");
`endif

endmodule : bottom_k_distinct_keeper_unit
`default_nettype wire

// ----- hw/rtl/bkdk_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bkdk_cell
// One slot of the sorted row: keeps the smaller of its value and the passing
// word, hands the larger on and flags equal values; an empty slot takes the word, or flags a drop past the keep count.
// ----------------------------------------------------------------------------
module bkdk_cell #(
    parameter int unsigned MAX_KEEP = bkdk_pkg::DEFAULT_MAX_KEEP,
    parameter int unsigned INDEX    = 0
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_adv,
    input  wire  bkdk_pkg::t_keep               i_keep,
    input  wire  [$clog2(MAX_KEEP+1)-1:0]       i_count,
    input  wire  bkdk_pkg::t_tok                i_tok,
    output bkdk_pkg::t_tok                      o_tok
);
    import bkdk_pkg::*;

    t_value r_val;
    t_value n_val;
    t_tok   r_tok;
    t_tok   n_tok;
    logic   w_full;
    logic   w_over;

    assign w_full = 32'(INDEX) < 32'(i_count);
    assign w_over = 32'(INDEX) >= 32'(i_keep);

    always_comb begin
        n_tok = i_tok;
        n_val = r_val;
        if (i_tok.live && !i_tok.clr && !i_tok.fin) begin
            if (w_full) begin
                if (i_tok.dup) begin
                    n_tok.last = r_val;
                end else if (i_tok.value == r_val) begin
                    n_tok.dup  = 1'b1;
                    n_tok.last = r_val;
                end else if (i_tok.value < r_val) begin
                    n_val       = i_tok.value;
                    n_tok.value = r_val;
                    n_tok.last  = i_tok.value;
                end else begin
                    n_tok.last = r_val;
                end
            end else begin
                n_tok.fin = 1'b1;
                if (!i_tok.dup) begin
                    if (w_over) begin
                        n_tok.drop = 1'b1;
                    end else begin
                        n_val      = i_tok.value;
                        n_tok.last = i_tok.value;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_val <= n_val;
        end
    end

    assign o_tok = r_tok;

endmodule : bkdk_cell
`default_nettype wire

// ----- verif/tb_bottom_k_distinct_keeper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bottom_k_distinct_keeper_unit
// Self-checking bench for the bottom-k keeper. A short directed run covers
// value extremes, duplicates, self-drops, clears and keep-count corners
// (zero, saturation, lowering without a clear). Random add/clear traffic then
// runs under a series of keep counts, with random idle on the input side and
// random stall on the result side. Each result word is checked field by field
// against a behavioral sorted store kept inside the bench.
// ----------------------------------------------------------------------------
module tb_bottom_k_distinct_keeper_unit;
    import bkdk_pkg::*;

    localparam int unsigned MAX_KEEP    = DEFAULT_MAX_KEEP;
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RECENT_MAX  = 48;

    typedef enum logic [1:0] {ENT_WORD, ENT_KEEP, ENT_DRAIN} t_plan_kind;

    typedef struct {
        t_plan_kind kind;
        t_in_word   word;
        t_keep      keep;
    } t_plan_entry;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;
    logic      i_cfg_we    = 1'b0;
    t_keep     i_cfg_wdata = '0;

    t_plan_entry word_plan [$];
    t_out_word   results_due [$];
    t_value      recent_vals [$];

    t_value      held_vals [0:MAX_KEEP];
    int unsigned held_n     = 0;
    t_keep       keep_k     = '0;

    bit          word_taken   = 1'b0;
    bit          result_taken = 1'b0;
    bit          send_burst   = 1'b0;
    bit          take_burst   = 1'b0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned cycle_count  = 0;
    int unsigned mismatches   = 0;

    bottom_k_distinct_keeper_unit #(
        .MAX_KEEP(MAX_KEEP)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_out_word bottom_k_update(t_in_word w);
        t_out_word   r;
        int unsigned lim;
        int unsigned pos;
        int unsigned i;
        bit          found;
        r     = '0;
        found = 1'b0;
        lim   = (32'(keep_k) > MAX_KEEP) ? MAX_KEEP : 32'(keep_k);
        if (w.mode == MODE_CLEAR) begin
            held_n = 0;
        end else begin
            for (i = 0; i < held_n; i++) begin
                if (held_vals[i] == w.value) found = 1'b1;
            end
            if (found) begin
                r.duplicate = 1'b1;
            end else begin
                if (held_n > MAX_KEEP) held_n = MAX_KEEP;
                pos = held_n;
                while (pos > 0 && held_vals[pos-1] > w.value) begin
                    held_vals[pos] = held_vals[pos-1];
                    pos--;
                end
                held_vals[pos] = w.value;
                held_n++;
                if (held_n > lim) begin
                    held_n--;
                    r.dropped_valid = 1'b1;
                    r.dropped_value = held_vals[held_n];
                end
            end
        end
        r.kept = held_n[KEPT_W-1:0];
        if (held_n > 0) r.largest = held_vals[held_n-1];
        return r;
    endfunction

    function automatic t_value pick_value();
        int unsigned sel;
        t_value      v;
        sel = $urandom_range(0, 99);
        if (sel < 35 && recent_vals.size() > 0) begin
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
        end else if (sel < 45) begin
            case ($urandom_range(0, 3))
                0: v = '0;
                1: v = '1;
                2: v = $urandom_range(0, 15);
                default: v = 32'hFFFF_FFFF - $urandom_range(0, 15);
            endcase
        end else begin
            v = $urandom();
        end
        return v;
    endfunction

    task automatic plan_word(logic mode, t_value value);
        t_plan_entry e;
        e.kind       = ENT_WORD;
        e.word.mode  = mode;
        e.word.value = value;
        e.keep       = '0;
        word_plan = {word_plan, e};
        if (mode == MODE_ADD) begin
            recent_vals = {recent_vals, value};
            if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
        end
    endtask

    task automatic plan_keep(t_keep k);
        t_plan_entry e;
        e.kind = ENT_KEEP;
        e.word = '0;
        e.keep = k;
        word_plan = {word_plan, e};
    endtask

    task automatic plan_drain();
        t_plan_entry e;
        e.kind = ENT_DRAIN;
        e.word = '0;
        e.keep = '0;
        word_plan = {word_plan, e};
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // input side: one word, keep write or drain per plan entry
    always @(negedge i_clk) begin : drive_words
        logic        nxt_valid;
        t_in_word    nxt_word;
        logic        nxt_we;
        t_keep       nxt_keep;
        t_plan_entry head;
        nxt_valid = i_in_valid;
        nxt_word  = i_in_word;
        nxt_we    = 1'b0;
        nxt_keep  = i_cfg_wdata;
        if (i_rst_n) begin
            if (word_taken) begin
                nxt_valid = 1'b0;
                gap_left  = send_burst ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
            end
            if (!nxt_valid && gap_left > 0) begin
                gap_left--;
            end else if (!nxt_valid && word_plan.size() > 0) begin
                head = word_plan[0];
                case (head.kind)
                    ENT_WORD: begin
                        nxt_valid = 1'b1;
                        nxt_word  = head.word;
                        void'(word_plan.pop_front());
                    end
                    ENT_KEEP: begin
                        if (results_due.size() == 0) begin
                            nxt_we   = 1'b1;
                            nxt_keep = head.keep;
                            void'(word_plan.pop_front());
                        end
                    end
                    default: begin
                        if (results_due.size() == 0) void'(word_plan.pop_front());
                    end
                endcase
            end
        end
        i_in_valid  <= nxt_valid;
        i_in_word   <= nxt_word;
        i_cfg_we    <= nxt_we;
        i_cfg_wdata <= nxt_keep;
    end

    // result side: hold stall for a drawn number of valid cycles
    always @(negedge i_clk) begin : drive_stall
        if (i_rst_n) begin
            if (result_taken) begin
                stall_left = take_burst ? 0 : $urandom_range(0, 11);
                if ($urandom_range(0, 19) == 0) take_burst = !take_burst;
            end else if (o_out_valid && stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_out_word want;
        t_out_word got;
        t_out_word pred;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end else begin
            word_taken   = i_rst_n && i_in_valid && !o_in_stall;
            result_taken = i_rst_n && o_out_valid && !i_out_stall;
            if (i_rst_n && i_cfg_we) keep_k = i_cfg_wdata;
            if (word_taken) begin
                pred        = bottom_k_update(i_in_word);
                results_due = {results_due, pred};
            end
            if (result_taken) begin
                got = o_out_word;
                if (results_due.size() == 0) begin
                    $display("%0t: result word with none expected, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    check_field("kept", 32'(want.kept), 32'(got.kept));
                    check_field("largest", want.largest, got.largest);
                    check_field("duplicate", 32'(want.duplicate), 32'(got.duplicate));
                    check_field("dropped_valid", 32'(want.dropped_valid),
                                32'(got.dropped_valid));
                    check_field("dropped_value", want.dropped_value, got.dropped_value);
                end
            end
        end
    end

    initial begin : run_test
        int          p;
        int unsigned i;
        int unsigned n_items;
        t_keep       k;

        plan_keep(t_keep'(4));
        plan_word(MODE_ADD, 32'h0000_0000);
        plan_word(MODE_ADD, 32'hFFFF_FFFF);
        plan_word(MODE_ADD, 32'h0000_0000);
        plan_word(MODE_ADD, 32'h0000_0005);
        plan_word(MODE_ADD, 32'h0000_0003);
        plan_word(MODE_ADD, 32'h8000_0000);
        plan_word(MODE_ADD, 32'h0000_0001);
        plan_word(MODE_ADD, 32'h7FFF_FFFF);
        plan_word(MODE_ADD, 32'h0000_0005);
        plan_word(MODE_CLEAR, 32'hFFFF_FFFF);
        plan_word(MODE_CLEAR, 32'h0000_0000);
        plan_word(MODE_ADD, 32'h5555_5555);
        plan_keep(t_keep'(0));
        plan_word(MODE_CLEAR, 32'h0000_0000);
        plan_word(MODE_ADD, 32'hAAAA_AAAA);
        plan_word(MODE_ADD, 32'hAAAA_AAAA);
        plan_keep(t_keep'(127));
        for (i = 1; i <= 8; i++) plan_word(MODE_ADD, i * 10);
        plan_keep(t_keep'(2));
        plan_word(MODE_ADD, 32'h0000_0005);
        plan_word(MODE_ADD, 32'h0000_005A);
        plan_word(MODE_CLEAR, 32'h0000_0000);

        for (p = 0; p < 12; p++) begin
            case (p)
                0: k = t_keep'(64);
                1: k = t_keep'(127);
                2: k = t_keep'(0);
                3: k = t_keep'(1);
                4: k = t_keep'(64);
                5: k = t_keep'(2);
                7: k = t_keep'(63);
                8: k = t_keep'(65);
                9: k = t_keep'(64);
                10: k = t_keep'(5);
                default: k = t_keep'($urandom_range(0, 127));
            endcase
            plan_keep(k);
            // odd phases carry the store over from the previous keep count
            if (p % 2 == 0) plan_word(MODE_CLEAR, $urandom());
            n_items = (k >= 60) ? 150 : 60;
            for (i = 0; i < n_items; i++) begin
                if (i == n_items / 2) plan_drain();
                if ($urandom_range(0, (k >= 60) ? 120 : 25) == 0)
                    plan_word(MODE_CLEAR, $urandom());
                else
                    plan_word(MODE_ADD, pick_value());
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_plan.size() != 0 || i_in_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (MAX_KEEP + 8) @(negedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
